// ===== design/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types, constants and helpers of the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int SIZE_WIDTH_DEF = 32;
  localparam int BYTE_WIDTH     = 8;
  localparam int LEN_WIDTH      = 32;
  localparam int STATUS_WIDTH   = 2;
  localparam int PADDR_WIDTH    = 3;
  localparam int PDATA_WIDTH    = 32;

  // register index, taken from paddr[2]
  localparam logic REG_CHUNKED_MODE = 1'b0;
  localparam logic REG_BODY_LENGTH  = 1'b1;

  localparam logic [BYTE_WIDTH-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_WIDTH-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_WIDTH-1:0] CH_COLON = 8'h3a;
  localparam logic [BYTE_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_WIDTH-1:0] CH_TAB   = 8'h09;

  typedef enum logic [3:0] {
    PH_SIZE     = 4'd0,
    PH_EXT      = 4'd1,
    PH_SIZE_LF  = 4'd2,
    PH_DATA     = 4'd3,
    PH_DATA_CR  = 4'd4,
    PH_DATA_LF  = 4'd5,
    PH_TRAIL    = 4'd6,
    PH_TRAIL_LF = 4'd7
  } phase_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_MORE = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0] out_byte;
    logic                  out_valid;
    status_t               status;
  } result_t;

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [BYTE_WIDTH-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== design/hcbd_ifs.sv =====
// ----------------------------------------------------------------------------
// hcbd channel interfaces
// raw body byte channel and decoded result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface hcbd_raw_if import hcbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BYTE_WIDTH-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hcbd_dec_if import hcbd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BYTE_WIDTH-1:0]   out_byte;
  logic                    out_valid;
  logic [STATUS_WIDTH-1:0] status;

  modport source (output valid, output out_byte, output out_valid, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input status,
                  output ready);
endinterface

// ===== design/hcbd_parser.sv =====
// ----------------------------------------------------------------------------
// hcbd_parser
// decoder state and per-byte update for length and chunked framing
// ----------------------------------------------------------------------------
module hcbd_parser import hcbd_pkg::*; #(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [BYTE_WIDTH-1:0] in_byte,
  input  logic                  chunked_mode,
  input  logic [LEN_WIDTH-1:0]  body_length,
  output result_t               res
);

  phase_t                phase, phase_next;
  logic [SIZE_WIDTH-1:0] chunk_remaining, chunk_remaining_next;
  logic                  digit_seen, digit_seen_next;
  logic                  line_has_colon, line_has_colon_next;
  logic                  line_empty, line_empty_next;
  logic [LEN_WIDTH-1:0]  bytes_passed, bytes_passed_next;
  status_t               final_status, final_status_next;

  logic       pass;
  logic [4:0] hex;
  logic       size_full;

  assign hex       = hex_value(in_byte);
  assign size_full = chunk_remaining[SIZE_WIDTH-1 -: 4] != 4'd0;

  // byte passes in the data phase or while the fixed length is not reached
  always_comb begin
    pass = 1'b0;
    if (final_status == ST_MORE) begin
      if (chunked_mode) begin
        pass = (phase == PH_DATA);
      end else begin
        pass = (bytes_passed < body_length);
      end
    end
  end

  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    digit_seen_next      = digit_seen;
    line_has_colon_next  = line_has_colon;
    line_empty_next      = line_empty;
    bytes_passed_next    = bytes_passed;
    final_status_next    = final_status;
    if (final_status == ST_MORE) begin
      if (chunked_mode) begin
        case (phase)
          PH_SIZE: begin
            if (hex[4]) begin
              if (size_full) begin
                final_status_next = ST_BAD;
              end else begin
                chunk_remaining_next = {chunk_remaining[SIZE_WIDTH-5:0], hex[3:0]};
                digit_seen_next      = 1'b1;
              end
            end else if (!digit_seen) begin
              if (in_byte != CH_SPACE && in_byte != CH_TAB) final_status_next = ST_BAD;
            end else if (in_byte == CH_CR) begin
              phase_next = PH_SIZE_LF;
            end else begin
              phase_next = PH_EXT;
            end
          end
          PH_EXT: begin
            if (in_byte == CH_CR) phase_next = PH_SIZE_LF;
          end
          PH_SIZE_LF: begin
            if (in_byte != CH_LF) begin
              final_status_next = ST_BAD;
            end else if (chunk_remaining == '0) begin
              phase_next          = PH_TRAIL;
              line_empty_next     = 1'b1;
              line_has_colon_next = 1'b0;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            chunk_remaining_next = chunk_remaining - SIZE_WIDTH'(1);
            if (chunk_remaining_next == '0) phase_next = PH_DATA_CR;
          end
          PH_DATA_CR: begin
            if (in_byte == CH_CR) phase_next = PH_DATA_LF;
            else final_status_next = ST_BAD;
          end
          PH_DATA_LF: begin
            if (in_byte == CH_LF) begin
              phase_next           = PH_SIZE;
              digit_seen_next      = 1'b0;
              chunk_remaining_next = '0;
            end else begin
              final_status_next = ST_BAD;
            end
          end
          PH_TRAIL: begin
            if (in_byte == CH_CR) begin
              phase_next = PH_TRAIL_LF;
            end else begin
              line_empty_next = 1'b0;
              if (in_byte == CH_COLON) line_has_colon_next = 1'b1;
            end
          end
          PH_TRAIL_LF: begin
            if (in_byte != CH_LF) begin
              final_status_next = ST_BAD;
            end else if (line_empty) begin
              final_status_next = ST_DONE;
            end else if (!line_has_colon) begin
              final_status_next = ST_BAD;
            end else begin
              phase_next          = PH_TRAIL;
              line_empty_next     = 1'b1;
              line_has_colon_next = 1'b0;
            end
          end
          default: final_status_next = ST_BAD;
        endcase
      end else if (pass) begin
        bytes_passed_next = bytes_passed + LEN_WIDTH'(1);
        if (bytes_passed_next == body_length) final_status_next = ST_DONE;
      end else begin
        final_status_next = ST_DONE;
      end
    end
  end

  assign res.out_byte  = pass ? in_byte : '0;
  assign res.out_valid = pass;
  assign res.status    = final_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      digit_seen      <= 1'b0;
      line_has_colon  <= 1'b0;
      line_empty      <= 1'b1;
      bytes_passed    <= '0;
      final_status    <= ST_MORE;
    end else if (step) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      digit_seen      <= digit_seen_next;
      line_has_colon  <= line_has_colon_next;
      line_empty      <= line_empty_next;
      bytes_passed    <= bytes_passed_next;
      final_status    <= final_status_next;
    end
  end

`ifndef ASSERT_OFF
  a_sticky_end: assert property (@(posedge clk) disable iff (rst)
    (final_status != ST_MORE) |=> (final_status == $past(final_status)))
    else $error("end status changed after done or error");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA && final_status == ST_MORE) |-> (chunk_remaining != '0))
    else $error("data phase with no bytes left in chunk");

  a_pass_phase: assert property (@(posedge clk) disable iff (rst)
    (res.out_valid && chunked_mode) |-> (phase == PH_DATA))
    else $error("byte passed outside chunk data");
`endif

endmodule

// ===== design/http_chunked_body_decoder_core.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// byte-serial http/1.1 body decoder, fixed-length or chunked framing
// pipeline: a raw item passes the input register, then the result register
// throughput: one byte per cycle while dec.ready holds, one parser update per byte
// reset: synchronous rst clears config, pipeline valids and parser state
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core import hcbd_pkg::*; #(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  hcbd_raw_if.sink               raw,
  hcbd_dec_if.source             dec,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [PDATA_WIDTH-1:0] pwdata,
  output logic [PDATA_WIDTH-1:0] prdata,
  output logic                   pready
);

  // configuration registers
  logic                 chunked_mode;
  logic [LEN_WIDTH-1:0] body_length;
  logic                 cfg_wr;

  // input register
  logic                  s1_valid;
  logic [BYTE_WIDTH-1:0] s1_byte;
  logic                  s1_adv;

  // result register
  logic    o_valid;
  result_t o_res;
  result_t res;

  // apb: pready tied high, register picked by paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode <= 1'b0;
      body_length  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CHUNKED_MODE) chunked_mode <= pwdata[0];
      else body_length <= pwdata[LEN_WIDTH-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_CHUNKED_MODE) prdata = {{(PDATA_WIDTH-1){1'b0}}, chunked_mode};
    else prdata = body_length;
  end

  // the parser step fires when the input register moves into the result
  // register; the result register is free or is being taken this cycle
  assign s1_adv    = s1_valid && (!o_valid || dec.ready);
  assign raw.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (raw.ready) begin
      s1_valid <= raw.valid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) s1_byte <= raw.in_byte;
  end

  hcbd_parser #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_adv),
    .in_byte      (s1_byte),
    .chunked_mode (chunked_mode),
    .body_length  (body_length),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (dec.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) o_res <= res;
  end

  assign dec.valid     = o_valid;
  assign dec.out_byte  = o_res.out_byte;
  assign dec.out_valid = o_res.out_valid;
  assign dec.status    = o_res.status;

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !o_valid |-> raw.ready)
    else $error("input stalled with empty result register");

  a_zero_when_dropped: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_res.out_valid) |-> (o_res.out_byte == '0))
    else $error("dropped byte shows nonzero data");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(s1_valid))
    else $error("result item without an input item");
`endif

endmodule
